### src/multi_server_job_dispatch_unit_assert.svh
// assertion macros for the job dispatch unit
`ifndef MULTI_SERVER_JOB_DISPATCH_UNIT_ASSERT_SVH
`define MULTI_SERVER_JOB_DISPATCH_UNIT_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define MSJD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define MSJD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/msjd_pkg.sv
// shared types and constants of the job dispatch unit
`default_nettype none

package msjd_pkg;

    localparam int CFG_W           = 7;
    localparam int ARR_W           = 32;
    localparam int DUR_W           = 32;
    localparam int TAG_W           = 20;
    localparam int SRV_W           = 6;
    localparam int TIME_W          = 48;
    localparam int MAX_SERVERS_DEF = 64;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    typedef struct packed {
        logic [ARR_W-1:0] arrival_time;
        logic [DUR_W-1:0] duration;
        logic [TAG_W-1:0] job_tag;
    } t_in_item;

    typedef struct packed {
        logic [TAG_W-1:0]  job_tag_out;
        logic [SRV_W-1:0]  server;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] finish_time;
    } t_out_item;

    // back part status toward the front queue
    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_stat;

endpackage

`default_nettype wire

### src/msjd_ram.sv
// generic single-write, single-read RAM with registered read data
`default_nettype none

module msjd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [AW-1:0]     i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [AW-1:0]     i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### src/msjd_front.sv
// front part: accepts jobs into a short register queue
`default_nettype none

module msjd_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire msjd_pkg::t_in_item  i_in,
    output logic                     o_in_stall,
    input  wire msjd_pkg::t_back_stat i_stat,
    output logic                     o_q_valid,
    output msjd_pkg::t_in_item       o_q_item
);

    localparam int DEPTH = msjd_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    msjd_pkg::t_in_item r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          push;
    logic          pop;

    // no jobs taken while the busy-until store is being cleared
    assign o_in_stall = (r_count == CW'(DEPTH)) || i_stat.clearing;
    assign push       = i_in_valid && !o_in_stall;
    assign pop        = i_stat.pop && (r_count != '0);
    assign o_q_valid  = (r_count != '0);
    assign o_q_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_mem[r_wr_ptr] <= i_in;
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/msjd_back.sv
// back part: scans busy-until times, picks a server and updates it
`default_nettype none

module msjd_back #(
    parameter int MAX_SERVERS = msjd_pkg::MAX_SERVERS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [msjd_pkg::CFG_W-1:0] i_servers_in_use,
    input  wire logic                       i_q_valid,
    input  wire msjd_pkg::t_in_item         i_q_item,
    output msjd_pkg::t_back_stat            o_stat,
    output logic                            o_out_valid,
    output msjd_pkg::t_out_item             o_out,
    input  wire logic                       i_out_stall
);

    localparam int IDX_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
    localparam int EXT_W  = (CNT_W > msjd_pkg::CFG_W) ? CNT_W : msjd_pkg::CFG_W;
    localparam int TIME_W = msjd_pkg::TIME_W;
    localparam int SRV_W  = msjd_pkg::SRV_W;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [IDX_W-1:0]           r_clr_idx;
    logic [msjd_pkg::ARR_W-1:0] r_arrival;
    logic [msjd_pkg::DUR_W-1:0] r_dur;
    logic [msjd_pkg::TAG_W-1:0] r_tag;
    logic [IDX_W-1:0]           r_issue_idx;
    logic                       r_issuing;
    logic                       r_cmp_valid;
    logic [IDX_W-1:0]           r_cmp_idx;
    logic                       r_found;
    logic [IDX_W-1:0]           r_chosen;
    logic [TIME_W-1:0]          r_min_val;
    logic [IDX_W-1:0]           r_min_idx;
    logic [TIME_W-1:0]          r_start;
    logic [TIME_W-1:0]          r_finish;

    logic [EXT_W-1:0]           cfg_ext;
    logic [EXT_W-1:0]           n_active;
    logic [IDX_W-1:0]           last_idx;
    logic [TIME_W-1:0]          rd_data;
    logic                       ram_we;
    logic [IDX_W-1:0]           ram_waddr;
    logic [TIME_W-1:0]          ram_wdata;
    logic                       is_free;
    logic                       is_min;
    logic [TIME_W-1:0]          calc_start;
    logic [TIME_W:0]            calc_sum;
    logic                       out_free;
    logic [SRV_W+IDX_W-1:0]     srv_ext;

    // zero servers counts as one, too many is capped at the pool size
    assign cfg_ext  = EXT_W'(i_servers_in_use);
    assign n_active = (cfg_ext == '0) ? EXT_W'(1)
                    : (cfg_ext > EXT_W'(MAX_SERVERS)) ? EXT_W'(MAX_SERVERS) : cfg_ext;
    assign last_idx = IDX_W'(n_active - EXT_W'(1));

    assign out_free  = !o_out_valid || !i_out_stall;
    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_DONE) && out_free);
    assign ram_waddr = (r_state == S_CLEAR) ? r_clr_idx : r_chosen;
    assign ram_wdata = (r_state == S_CLEAR) ? '0 : r_finish;

    assign is_free = (rd_data <= TIME_W'(r_arrival));
    assign is_min  = (r_cmp_idx == '0) || (rd_data < r_min_val);

    assign calc_start = r_found ? TIME_W'(r_arrival) : r_min_val;
    assign calc_sum   = {1'b0, calc_start} + (TIME_W + 1)'(r_dur);
    assign srv_ext    = {{SRV_W{1'b0}}, r_chosen};

    assign o_stat.pop      = (r_state == S_IDLE) && i_q_valid;
    assign o_stat.clearing = (r_state == S_CLEAR);

    msjd_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MAX_SERVERS)
    ) u_busy_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_issue_idx),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_issue_idx <= '0;
            r_issuing   <= 1'b0;
            r_cmp_valid <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_idx <= r_clr_idx + IDX_W'(1);
                    if (r_clr_idx == IDX_W'(MAX_SERVERS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_cmp_valid <= 1'b0;
                    if (i_q_valid) begin
                        r_arrival   <= i_q_item.arrival_time;
                        r_dur       <= i_q_item.duration;
                        r_tag       <= i_q_item.job_tag;
                        r_issue_idx <= '0;
                        r_issuing   <= 1'b1;
                        r_found     <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // the compare handles the read issued in the previous cycle
                    r_cmp_valid <= r_issuing;
                    r_cmp_idx   <= r_issue_idx;
                    if (r_issuing) begin
                        if (r_issue_idx == last_idx) begin
                            r_issuing <= 1'b0;
                        end else begin
                            r_issue_idx <= r_issue_idx + IDX_W'(1);
                        end
                    end
                    if (r_cmp_valid) begin
                        if (!r_found && is_free) begin
                            r_found  <= 1'b1;
                            r_chosen <= r_cmp_idx;
                        end
                        if (is_min) begin
                            r_min_val <= rd_data;
                            r_min_idx <= r_cmp_idx;
                        end
                        if (r_cmp_idx == last_idx) begin
                            r_state <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    r_start  <= calc_start;
                    r_finish <= calc_sum[TIME_W] ? msjd_pkg::TIME_MAX : calc_sum[TIME_W-1:0];
                    if (!r_found) begin
                        r_chosen <= r_min_idx;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid       <= 1'b1;
                        o_out.job_tag_out <= r_tag;
                        o_out.server      <= srv_ext[SRV_W-1:0];
                        o_out.start_time  <= r_start;
                        o_out.finish_time <= r_finish;
                        r_issue_idx       <= '0;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/multi_server_job_dispatch_unit.sv
// top level of the multi-server job dispatch unit
`default_nettype none

// Dispatches jobs to a pool of servers by earliest-free policy: a job goes to
// the lowest-numbered server whose busy-until time is at most its arrival,
// otherwise to the server that frees up first (lowest index on ties), and that
// server's busy-until time becomes the saturated finish time. A two-entry
// input queue decouples job intake from the dispatch engine. The engine reads
// the busy-until memory one server per cycle, then computes start and finish
// times and registers the result; the result register lets the next job start
// while a result waits. After reset the busy-until memory is zeroed one entry
// per cycle, during which o_in_stall is high; configuration writes are always
// taken and must only happen while the unit is idle.
module multi_server_job_dispatch_unit #(
    parameter int MAX_SERVERS = msjd_pkg::MAX_SERVERS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    input  wire msjd_pkg::t_in_item         i_in,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output msjd_pkg::t_out_item             o_out,
    input  wire logic                       i_out_stall,
    input  wire logic                       i_cfg_valid,
    input  wire logic [msjd_pkg::CFG_W-1:0] i_cfg_data,
    output logic                            o_cfg_ready
);

    logic [msjd_pkg::CFG_W-1:0] r_servers_in_use;
    logic                       q_valid;
    msjd_pkg::t_in_item         q_item;
    msjd_pkg::t_back_stat       back_stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_servers_in_use <= msjd_pkg::CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_servers_in_use <= i_cfg_data;
        end
    end

    msjd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_stat     (back_stat),
        .o_q_valid  (q_valid),
        .o_q_item   (q_item)
    );

    msjd_back #(
        .MAX_SERVERS (MAX_SERVERS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_servers_in_use (r_servers_in_use),
        .i_q_valid        (q_valid),
        .i_q_item         (q_item),
        .o_stat           (back_stat),
        .o_out_valid      (o_out_valid),
        .o_out            (o_out),
        .i_out_stall      (i_out_stall)
    );

endmodule

`default_nettype wire

### src/msjd_checker.sv
// port-level checks of the job dispatch unit, bound to the top level
`default_nettype none

`include "multi_server_job_dispatch_unit_assert.svh"

module msjd_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire msjd_pkg::t_in_item  i_in,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire msjd_pkg::t_out_item o_out,
    input wire logic                i_out_stall
);

    localparam logic [msjd_pkg::TIME_W-1:0] SPAN_MAX =
        {{(msjd_pkg::TIME_W - msjd_pkg::DUR_W){1'b0}}, {msjd_pkg::DUR_W{1'b1}}};

    logic                        in_held;
    logic                        out_held;
    logic                        quiet;
    logic                        order_ok;
    logic [msjd_pkg::TIME_W-1:0] span;
    logic                        span_ok;

    assign in_held  = i_in_valid && o_in_stall;
    assign out_held = o_out_valid && i_out_stall;
    assign quiet    = o_in_stall && !o_out_valid;
    assign order_ok = o_out.finish_time >= o_out.start_time;
    assign span     = o_out.finish_time - o_out.start_time;
    assign span_ok  = span <= SPAN_MAX;

    `MSJD_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, in_held, $stable({i_in_valid, i_in}), "job moved")
    `MSJD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, $stable({o_out_valid, o_out}), "result moved")
    `MSJD_ASSERT_IMPL(a_finish_order, i_clk, i_rst_n, o_out_valid, order_ok, "finish before start")
    `MSJD_ASSERT_IMPL(a_span_bound, i_clk, i_rst_n, o_out_valid, span_ok, "span too long")
    `MSJD_ASSERT_NEXT(a_clear_after_reset, i_clk, 1'b1, !i_rst_n, quiet, "open after reset")

endmodule

bind multi_server_job_dispatch_unit msjd_checker u_checker (.*);

`default_nettype wire

### dv/multi_server_job_dispatch_unit_test.sv
// self-checking testbench of the multi-server job dispatch unit
module multi_server_job_dispatch_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ARR_W    = msjd_pkg::ARR_W;
    localparam int          DUR_W    = msjd_pkg::DUR_W;
    localparam int          TAG_W    = msjd_pkg::TAG_W;
    localparam int          SRV_W    = msjd_pkg::SRV_W;
    localparam int          TIME_W   = msjd_pkg::TIME_W;
    localparam int          CFG_W    = msjd_pkg::CFG_W;
    localparam int          N_SRV    = msjd_pkg::MAX_SERVERS_DEF;
    localparam int          IDLE_PCT = 21;
    localparam int unsigned ARR_TOP  = 32'hFFFF_FFFF;
    localparam int unsigned DUR_TOP  = 32'hFFFF_FFFF;
    localparam int unsigned TAG_TOP  = (1 << TAG_W) - 1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    msjd_pkg::t_in_item  in_item = '0;
    logic                in_stall;
    logic                out_valid;
    msjd_pkg::t_out_item out_item;
    logic                out_stall = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                cfg_ready;

    // predictor state: busy-until time per server and the server count register
    logic [TIME_W-1:0] srv_free_at [N_SRV];
    logic [CFG_W-1:0]  srv_count = msjd_pkg::CFG_RESET;

    msjd_pkg::t_in_item  pend_jobs [$];
    msjd_pkg::t_out_item due_dispatches [$];
    msjd_pkg::t_out_item want;
    int                  mismatches = 0;
    bit                  steady = 1'b0;

    multi_server_job_dispatch_unit uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in        (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_item),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // earliest-free dispatch of one job, updating the busy-until times
    function automatic msjd_pkg::t_out_item dispatch_job(msjd_pkg::t_in_item job);
        int unsigned         n;
        int unsigned         pick;
        int unsigned         early;
        bit                  found;
        logic [TIME_W-1:0]   arrival;
        logic [TIME_W-1:0]   start;
        logic [TIME_W:0]     sum;
        logic [TIME_W-1:0]   finish;
        msjd_pkg::t_out_item res;
        if (srv_count == '0)
            n = 1;
        else if (32'(srv_count) > N_SRV)
            n = N_SRV;
        else
            n = 32'(srv_count);
        arrival = {{(TIME_W-ARR_W){1'b0}}, job.arrival_time};
        found = 1'b0;
        pick = 0;
        early = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (!found && srv_free_at[i] <= arrival) begin
                found = 1'b1;
                pick = i;
            end
            if (srv_free_at[i] < srv_free_at[early])
                early = i;
        end
        if (found) begin
            start = arrival;
        end else begin
            pick = early;
            start = srv_free_at[early];
        end
        sum = {1'b0, start} + {{(TIME_W+1-DUR_W){1'b0}}, job.duration};
        finish = (sum > {1'b0, msjd_pkg::TIME_MAX}) ? msjd_pkg::TIME_MAX : sum[TIME_W-1:0];
        srv_free_at[pick] = finish;
        res.job_tag_out = job.job_tag;
        res.server = pick[SRV_W-1:0];
        res.start_time = start;
        res.finish_time = finish;
        return res;
    endfunction

    // job driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                due_dispatches = {due_dispatches, dispatch_job(in_item)};
            if (!in_valid || !in_stall) begin
                if (pend_jobs.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
                    in_valid <= 1'b1;
                    in_item <= pend_jobs.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (due_dispatches.size() == 0) begin
                    $error("unexpected dispatch transaction, tag %0h", out_item.job_tag_out);
                    mismatches++;
                end else begin
                    want = due_dispatches.pop_front();
                    if (out_item.job_tag_out !== want.job_tag_out) begin
                        $error("job_tag_out: expected %0h, got %0h",
                               want.job_tag_out, out_item.job_tag_out);
                        mismatches++;
                    end
                    if (out_item.server !== want.server) begin
                        $error("server: expected %0d, got %0d", want.server, out_item.server);
                        mismatches++;
                    end
                    if (out_item.start_time !== want.start_time) begin
                        $error("start_time: expected %0h, got %0h",
                               want.start_time, out_item.start_time);
                        mismatches++;
                    end
                    if (out_item.finish_time !== want.finish_time) begin
                        $error("finish_time: expected %0h, got %0h",
                               want.finish_time, out_item.finish_time);
                        mismatches++;
                    end
                end
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic push_job(int unsigned arr, int unsigned dur, int unsigned tag);
        msjd_pkg::t_in_item job;
        job.arrival_time = ARR_W'(arr);
        job.duration = DUR_W'(dur);
        job.job_tag = TAG_W'(tag);
        pend_jobs = {pend_jobs, job};
    endtask

    // looked at on the falling edge, clear of the updates at the rising edge
    task automatic wait_drained();
        @(negedge clk);
        while (pend_jobs.size() > 0 || in_valid || due_dispatches.size() > 0)
            @(negedge clk);
    endtask

    // register write, only once every dispatch has come back
    task automatic set_servers(int unsigned value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= CFG_W'(value);
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        srv_count = CFG_W'(value);
    endtask

    // mostly steady arrivals with random gaps and bursts, a few late or wild ones
    task automatic queue_phase(int cnt, int unsigned servers, bit wide, int unsigned base);
        longint unsigned now;
        int unsigned     arr;
        int unsigned     dur;
        int unsigned     roll;
        now = 64'(base);
        for (int k = 0; k < cnt; k++) begin
            if ($urandom_range(99) >= 15)
                now = now + 64'($urandom_range(0, 40));
            if (now > 64'(ARR_TOP))
                now = 64'(ARR_TOP);
            arr = 32'(now);
            roll = $urandom_range(99);
            if (roll < 3)
                arr = arr - $urandom_range(0, 500);
            else if (wide && roll < 4)
                arr = $urandom();
            roll = $urandom_range(99);
            if (wide && roll < 3)
                dur = $urandom();
            else if (roll < 13)
                dur = 16;
            else
                dur = $urandom_range(0, servers * 40 + 40);
            push_job(arr, dur, $urandom_range(0, TAG_TOP));
        end
    endtask

    initial begin
        for (int i = 0; i < N_SRV; i++)
            srv_free_at[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset server count, free and tied servers
        push_job(0, 0, 0);
        push_job(0, 10, TAG_TOP);
        push_job(0, 10, 1);
        push_job(5, 3, 2);
        push_job(10, 1, 3);
        // a count of zero acts as one server, arrival going backwards
        set_servers(0);
        push_job(20, 5, 4);
        push_job(21, 4, 5);
        push_job(3, 0, 6);
        // count above the pool acts as the whole pool
        set_servers(127);
        push_job(30, 100, 7);
        push_job(30, 100, 8);
        // widest arrival and duration on a single server
        set_servers(1);
        push_job(ARR_TOP, DUR_TOP, 9);
        push_job(ARR_TOP, 0, 10);
        push_job(0, DUR_TOP, 11);
        set_servers(64);
        push_job(40, 7, 12);
        push_job(40, 7, 13);
        push_job(41, 0, TAG_TOP);

        set_servers(3);
        queue_phase(100, 3, 1'b0, $urandom_range(0, 32'h0FFF_FFFF));
        set_servers(4);
        queue_phase(100, 4, 1'b0, 32'h2000_0000 + $urandom_range(0, 32'h0FFF_FFFF));
        set_servers($urandom_range(5, 63));
        queue_phase(110, 32'(srv_count), 1'b0,
                    32'h4000_0000 + $urandom_range(0, 32'h0FFF_FFFF));
        set_servers(64);
        steady = 1'b1;
        queue_phase(120, 64, 1'b1, 32'h6000_0000 + $urandom_range(0, 32'h0FFF_FFFF));
        wait_drained();
        steady = 1'b0;
        set_servers(127);
        queue_phase(110, 64, 1'b1, 32'h8000_0000 + $urandom_range(0, 32'h0FFF_FFFF));
        set_servers($urandom_range(65, 126));
        queue_phase(100, 64, 1'b1, 32'hA000_0000 + $urandom_range(0, 32'h0FFF_FFFF));
        set_servers($urandom_range(2, 63));
        queue_phase(100, 32'(srv_count), 1'b1,
                    32'hC000_0000 + $urandom_range(0, 32'h0FFF_FFFF));
        set_servers(64);
        queue_phase(110, 64, 1'b1, 32'hE000_0000 + $urandom_range(0, 32'h0FFF_FFFF));

        wait_drained();
        repeat (80) @(posedge clk);
        if (mismatches == 0 && due_dispatches.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
